FILE: rtl/core/ast_pkg.sv
// ast_pkg: shared types, codes and character constants for the assembler
// source tokenizer. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

    // scan modes of the tokenizer
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_STRING,
        MODE_COMMENT,
        MODE_HALTED
    } t_mode;

    // result kinds as seen on the output channel
    typedef enum logic [2:0] {
        KIND_END,
        KIND_EOL,
        KIND_PRE,
        KIND_ID,
        KIND_STR,
        KIND_BAD,
        KIND_UNTERM,
        KIND_LONG
    } t_kind;

    // tokenizer state carried from one character to the next
    typedef struct packed {
        t_mode      mode;
        logic       is_id;
        logic [7:0] len;
    } t_state;

    // one result item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_char;
        logic       has_char;
        logic       token_end;
        logic       item_done;
    } t_result;

    // everything one character produces: next state and up to two results
    typedef struct packed {
        t_state     nxt;
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_step_out;

    // longest word or string held
    localparam logic [7:0] MAX_LEN = 8'd254;

    // result queue size
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

endpackage

`default_nettype wire

FILE: rtl/core/ast_if.sv
// ast_in_if / ast_out_if: valid/ready channels of the tokenizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ast_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface ast_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_char;
    logic       has_char;
    logic       token_end;
    logic       item_done;

    modport source (output valid, output kind, output out_char, output has_char,
                    output token_end, output item_done, input ready);
    modport sink   (input valid, input kind, input out_char, input has_char,
                    input token_end, input item_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ast_step.sv
// ast_step: character classification and scan-mode update for one input.
// Depends on ast_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ast_step
    import ast_pkg::*;
#(
    parameter logic [7:0] MAX_TOKEN_LEN = MAX_LEN
)
(
    input  var t_state    i_state,
    input  var logic [7:0] i_ch,
    input  var logic      i_eoi,
    output t_step_out     o_step
);

    typedef struct packed {
        t_state  nxt;
        logic    emit;
        t_result res;
    } t_idle_out;

    function automatic t_result mk_res(t_kind k, logic [7:0] c, logic has, logic fin);
        t_result r;
        r.kind      = k;
        r.out_char  = has ? c : 8'd0;
        r.has_char  = has;
        r.token_end = fin;
        r.item_done = 1'b0;
        return r;
    endfunction

    // handling of a character seen between tokens
    function automatic t_idle_out from_idle(t_state st, logic [7:0] c, logic eoi);
        t_idle_out o;
        logic      blank;
        logic      id_start;
        blank    = (c == CH_SPACE) || (c == CH_TAB);
        id_start = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                   (c == CH_DOT) || (c == CH_DOLL);
        o.nxt     = st;
        o.nxt.len = 8'd0;
        o.emit    = 1'b0;
        o.res     = mk_res(KIND_END, 8'd0, 1'b0, 1'b1);
        if (eoi) begin
            o.emit = 1'b1;
        end else if (blank) begin
            o.emit = 1'b0;
        end else if (c == CH_NL) begin
            o.emit = 1'b1;
            o.res  = mk_res(KIND_EOL, CH_NL, 1'b1, 1'b1);
        end else if (c == CH_PCT || id_start) begin
            o.nxt.is_id = (c != CH_PCT);
            o.nxt.mode  = MODE_WORD;
            o.nxt.len   = 8'd1;
            o.emit      = 1'b1;
            o.res       = mk_res((c != CH_PCT) ? KIND_ID : KIND_PRE, c, 1'b1, 1'b0);
        end else if (c == CH_QUOTE) begin
            o.nxt.mode = MODE_STRING;
        end else if (c == CH_SEMI) begin
            o.nxt.mode = MODE_COMMENT;
        end else begin
            o.nxt.mode = MODE_HALTED;
            o.emit     = 1'b1;
            o.res      = mk_res(KIND_BAD, c, 1'b1, 1'b0);
        end
        return o;
    endfunction

    t_state    idle_st;
    t_idle_out idle_o;
    t_kind     word_kind;
    logic      blank;
    logic      too_long;
    t_step_out so;

    // idle handling is shared by the between-tokens case and the word cut
    always_comb begin
        idle_st      = i_state;
        idle_st.mode = MODE_IDLE;
        idle_o       = from_idle(idle_st, i_ch, i_eoi);
        word_kind    = i_state.is_id ? KIND_ID : KIND_PRE;
        blank        = (i_ch == CH_SPACE) || (i_ch == CH_TAB);
        too_long     = (i_state.len >= MAX_TOKEN_LEN);
    end

    // mode update and result selection
    always_comb begin
        so.nxt = i_state;
        so.cnt = 2'd0;
        so.r0  = mk_res(KIND_END, 8'd0, 1'b0, 1'b1);
        so.r1  = mk_res(KIND_END, 8'd0, 1'b0, 1'b1);
        unique case (i_state.mode)
            MODE_IDLE: begin
                so.nxt = idle_o.nxt;
                so.cnt = {1'b0, idle_o.emit};
                so.r0  = idle_o.res;
            end
            MODE_WORD: begin
                if (i_eoi || blank || i_ch == CH_NL) begin
                    so.r0       = mk_res(word_kind, 8'd0, 1'b0, 1'b1);
                    so.nxt.mode = MODE_IDLE;
                    so.nxt.len  = 8'd0;
                    if (i_eoi) begin
                        so.cnt = 2'd2;
                    end else if (i_ch == CH_NL) begin
                        so.cnt = 2'd2;
                        so.r1  = mk_res(KIND_EOL, CH_NL, 1'b1, 1'b1);
                    end else begin
                        so.cnt = 2'd1;
                    end
                end else if (too_long) begin
                    // word cut: close it, then the character is handled as between tokens
                    so.r0  = mk_res(word_kind, 8'd0, 1'b0, 1'b1);
                    so.nxt = idle_o.nxt;
                    so.cnt = idle_o.emit ? 2'd2 : 2'd1;
                    so.r1  = idle_o.res;
                end else begin
                    so.nxt.len = i_state.len + 8'd1;
                    so.cnt     = 2'd1;
                    so.r0      = mk_res(word_kind, i_ch, 1'b1, 1'b0);
                end
            end
            MODE_STRING: begin
                so.cnt = 2'd1;
                if (i_eoi || i_ch == CH_NL) begin
                    so.nxt.mode = MODE_HALTED;
                    so.r0       = mk_res(KIND_UNTERM, 8'd0, 1'b0, 1'b0);
                end else if (i_ch == CH_QUOTE) begin
                    so.nxt.mode = MODE_IDLE;
                    so.nxt.len  = 8'd0;
                    so.r0       = mk_res(KIND_STR, 8'd0, 1'b0, 1'b1);
                end else if (too_long) begin
                    so.nxt.mode = MODE_HALTED;
                    so.r0       = mk_res(KIND_LONG, 8'd0, 1'b0, 1'b0);
                end else begin
                    so.nxt.len = i_state.len + 8'd1;
                    so.r0      = mk_res(KIND_STR, i_ch, 1'b1, 1'b0);
                end
            end
            MODE_COMMENT: begin
                if (i_eoi) begin
                    so.nxt.mode = MODE_IDLE;
                    so.cnt      = 2'd1;
                end else if (i_ch == CH_NL) begin
                    so.nxt.mode = MODE_IDLE;
                    so.cnt      = 2'd1;
                    so.r0       = mk_res(KIND_EOL, CH_NL, 1'b1, 1'b1);
                end
            end
            default: begin
                so.nxt.mode = MODE_HALTED;
            end
        endcase
        // mark the last result of this character
        if (so.cnt == 2'd2) begin
            so.r1.item_done = 1'b1;
        end else begin
            so.r0.item_done = 1'b1;
        end
    end

    assign o_step = so;

endmodule

`default_nettype wire

FILE: rtl/core/ast_rq.sv
// ast_rq: small result queue, takes up to two results per cycle and
// hands out one. Depends on ast_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ast_rq
    import ast_pkg::*;
(
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var logic [1:0] i_push_cnt,
    input  var t_result    i_r0,
    input  var t_result    i_r1,
    input  var logic       i_pop,
    output t_result        o_head,
    output logic           o_valid,
    output logic           o_room
);

    t_result           r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]  r_wr;
    logic [RQ_AW-1:0]  r_rd;
    logic [RQ_CW-1:0]  r_count;
    logic [RQ_AW-1:0]  n_wr1;

    assign n_wr1 = r_wr + RQ_AW'(1);

    // storage writes
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_r0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[n_wr1] <= i_r1;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + RQ_AW'(i_push_cnt);
            r_rd    <= r_rd + RQ_AW'(i_pop);
            r_count <= r_count + RQ_CW'(i_push_cnt) - RQ_CW'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    // room for a character that makes two results
    assign o_room  = (r_count <= RQ_CW'(RQ_DEPTH - 2));

endmodule

`default_nettype wire

FILE: rtl/core/assembler_source_tokenizer_core.sv
// assembler_source_tokenizer_core: top level of the assembler source tokenizer.
// Depends on ast_pkg, ast_if, ast_step and ast_rq.
//
//  channel  | dir | payload                                          | transfer
//  ---------+-----+--------------------------------------------------+--------------------
//  i_in     | in  | ch[7:0], end_of_input                            | valid && ready
//  o_out    | out | kind[2:0], out_char[7:0], has_char, token_end,   | valid && ready
//           |     | item_done                                        |
//
// Each character is decoded in the cycle it is accepted; its results are registered
// into a four-entry result queue. One character per cycle is taken while the queue
// has two free entries, so characters that make one result stream at one per cycle
// while the output is ready; the output port moves one result per cycle when ready,
// which sets the rate when characters make two. Reset (synchronous, active low)
// returns the scanner to between-tokens and empties the queue. A stalled output
// only holds the input once the queue is nearly full.
`timescale 1ns / 1ps
`default_nettype none

module assembler_source_tokenizer_core
    import ast_pkg::*;
#(
    parameter logic [7:0] MAX_TOKEN_LEN = MAX_LEN
)
(
    input  var logic  i_clk,
    input  var logic  i_rst_n,
    ast_in_if.sink    i_in,
    ast_out_if.source o_out
);

    t_state    r_state;
    t_state    n_state;
    t_step_out step;
    t_result   head;
    logic      accept;
    logic      room;
    logic      q_valid;

    ast_step #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_step (
        .i_state (r_state),
        .i_ch    (i_in.ch),
        .i_eoi   (i_in.end_of_input),
        .o_step  (step)
    );

    assign accept = i_in.valid && room;

    // scanner state advances on each input transfer
    always_comb begin
        n_state = accept ? step.nxt : r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode  <= MODE_IDLE;
            r_state.is_id <= 1'b0;
            r_state.len   <= 8'd0;
        end else begin
            r_state <= n_state;
        end
    end

    ast_rq u_rq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (accept ? step.cnt : 2'd0),
        .i_r0       (step.r0),
        .i_r1       (step.r1),
        .i_pop      (q_valid && o_out.ready),
        .o_head     (head),
        .o_valid    (q_valid),
        .o_room     (room)
    );

    // channel outputs
    assign i_in.ready      = room;
    assign o_out.valid     = q_valid;
    assign o_out.kind      = head.kind;
    assign o_out.out_char  = head.out_char;
    assign o_out.has_char  = head.has_char;
    assign o_out.token_end = head.token_end;
    assign o_out.item_done = head.item_done;

endmodule

`default_nettype wire

FILE: rtl/core/ast_chk.sv
// ast_chk: port-level checks of the tokenizer output channel, and the bind
// that attaches them to the top level. Depends on ast_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ast_chk
    import ast_pkg::*;
(
    input var logic       i_clk,
    input var logic       i_rst_n,
    input var logic       i_out_valid,
    input var logic       i_out_ready,
    input var logic [2:0] i_kind,
    input var logic [7:0] i_out_char,
    input var logic       i_has_char,
    input var logic       i_token_end,
    input var logic       i_item_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_kind, i_out_char, i_has_char, i_token_end, i_item_done}))
        else $error("output result changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // error results never close a token and always end the item
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_BAD || i_kind == KIND_UNTERM ||
        i_kind == KIND_LONG) |-> !i_token_end && i_item_done)
        else $error("malformed error result");

    // end results carry no character and close a token
    a_end_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_END |-> !i_has_char && i_token_end &&
        i_item_done)
        else $error("malformed end result");

    // end-of-line carries the newline character
    a_eol_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_EOL |-> i_has_char && i_out_char == CH_NL &&
        i_token_end && i_item_done)
        else $error("malformed end-of-line result");

endmodule

bind assembler_source_tokenizer_core ast_chk u_ast_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.kind),
    .i_out_char  (o_out.out_char),
    .i_has_char  (o_out.has_char),
    .i_token_end (o_out.token_end),
    .i_item_done (o_out.item_done)
);

`default_nettype wire
